// ===== sv/tet_pkg.sv =====
package tet_pkg;

  // event types
  localparam logic [15:0] EV_SYN = 16'h0000;
  localparam logic [15:0] EV_KEY = 16'h0001;
  localparam logic [15:0] EV_REL = 16'h0002;
  localparam logic [15:0] EV_ABS = 16'h0003;

  // event codes
  localparam logic [15:0] SYNC_FRAME       = 16'h0000;
  localparam logic [15:0] SYNC_CONTACT     = 16'h0002;
  localparam logic [15:0] REL_Z            = 16'h0002;
  localparam logic [15:0] ABS_X            = 16'h0000;
  localparam logic [15:0] ABS_Y            = 16'h0001;
  localparam logic [15:0] ABS_MT_PACKED    = 16'h002a;
  localparam logic [15:0] ABS_MT_MAJOR     = 16'h0030;
  localparam logic [15:0] ABS_MT_MINOR     = 16'h0031;
  localparam logic [15:0] ABS_MT_WMAJOR    = 16'h0032;
  localparam logic [15:0] ABS_MT_WMINOR    = 16'h0033;
  localparam logic [15:0] ABS_MT_POS_X     = 16'h0035;
  localparam logic [15:0] ABS_MT_POS_Y     = 16'h0036;
  localparam logic [15:0] ABS_MT_TRACK_ID  = 16'h0039;
  localparam logic [15:0] ABS_MT_FORCE     = 16'h003a;
  localparam logic [15:0] CODE_RELEASE     = 16'h0000;
  localparam logic [15:0] CODE_TOUCH       = 16'h0001;

  // value constants
  localparam logic [31:0] PACK_X_MASK      = 32'h7FFF0000;
  localparam logic [31:0] RELEASE_SENTINEL = 32'h80000000;
  localparam logic [31:0] POS_NONE         = 32'hFFFFFFFF;

  // register indexes
  localparam logic [2:0] REG_SCREEN_W  = 3'd0;
  localparam logic [2:0] REG_SCREEN_H  = 3'd1;
  localparam logic [2:0] REG_SINGLE_XL = 3'd2;
  localparam logic [2:0] REG_SINGLE_YL = 3'd3;
  localparam logic [2:0] REG_MULTI_XL  = 3'd4;
  localparam logic [2:0] REG_MULTI_YL  = 3'd5;
  localparam logic [2:0] REG_KEY_COUNT = 3'd6;

  // scaling divider widths
  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = 17;
  localparam int DIV_MAG_W = 49;
  localparam int DIV_REM_W = 16;
  localparam int DIV_CNT_W = 6;

  typedef struct packed {
    logic [15:0] scan;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] w;
    logic [15:0] h;
  } key_entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EVAL,
    S_MUL,
    S_DIVGO,
    S_DIVWAIT,
    S_POST,
    S_RD,
    S_CHK,
    S_FINAL,
    S_EMIT
  } state_t;

endpackage

// ===== sv/tet_if.sv =====
interface tet_event_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [15:0]        ev_type;
  logic [15:0]        ev_code;
  logic signed [31:0] ev_value;
  logic [3:0]         key_index;
  logic [15:0]        key_scancode;
  logic [15:0]        key_center_x;
  logic [15:0]        key_center_y;
  logic [15:0]        key_width;
  logic [15:0]        key_height;

  modport source (
    output valid, cmd, ev_type, ev_code, ev_value, key_index, key_scancode,
           key_center_x, key_center_y, key_width, key_height,
    input  ready
  );
  modport sink (
    input  valid, cmd, ev_type, ev_code, ev_value, key_index, key_scancode,
           key_center_x, key_center_y, key_width, key_height,
    output ready
  );
endinterface

interface tet_result_if;
  logic               valid;
  logic               ready;
  logic [15:0]        out_type;
  logic [15:0]        out_code;
  logic signed [31:0] out_value;
  logic               haptic_pulse;

  modport source (
    output valid, out_type, out_code, out_value, haptic_pulse,
    input  ready
  );
  modport sink (
    input  valid, out_type, out_code, out_value, haptic_pulse,
    output ready
  );
endinterface

// ===== sv/touch_event_translator.sv =====
// Touch event translator.
// The events channel takes raw input events (type, code, value) or, with cmd
// set, a write of one virtual key table entry. The results channel gives at
// most one event per input: touch (sent again as the contact moves), release,
// a virtual key press with a haptic pulse or its release, or the forwarded
// event. Screen size, axis limits and the key count are set over the APB
// port; the user must write them only while the block is idle, which the
// block itself does not enforce. One item is in work at a time. A report
// that needs scaling runs one multiply and one 49-step serial divide per
// axis; on a first touch it then reads the key table entries from the table
// memory one by one until one is hit. Unscaled reports skip the divider.
// A finished result sits in the output register; the next item is accepted
// while it waits. If the receiver stalls and a second result is ready, the
// block holds it and takes no new item until the output register frees.
// Reset clears all tracking state and the configuration to its defaults and
// leaves the key table contents as they are; entries must be written before
// key_count covers them.
module touch_event_translator #(
  parameter int MAX_KEYS = 16
) (
  input  logic                clk,
  input  logic                rst,
  tet_event_if.sink           events,
  tet_result_if.source        results,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_W = $clog2(MAX_KEYS + 1);

  // configuration registers
  logic [15:0] scr_w;
  logic [15:0] scr_h;
  logic [31:0] s_xl;
  logic [31:0] s_yl;
  logic [31:0] m_xl;
  logic [31:0] m_yl;
  logic [4:0]  key_count;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w     <= 16'd1080;
      scr_h     <= 16'd1920;
      s_xl      <= '0;
      s_yl      <= '0;
      m_xl      <= '0;
      m_yl      <= '0;
      key_count <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        tet_pkg::REG_SCREEN_W:  scr_w     <= pwdata[15:0];
        tet_pkg::REG_SCREEN_H:  scr_h     <= pwdata[15:0];
        tet_pkg::REG_SINGLE_XL: s_xl      <= pwdata;
        tet_pkg::REG_SINGLE_YL: s_yl      <= pwdata;
        tet_pkg::REG_MULTI_XL:  m_xl      <= pwdata;
        tet_pkg::REG_MULTI_YL:  m_yl      <= pwdata;
        tet_pkg::REG_KEY_COUNT: key_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      tet_pkg::REG_SCREEN_W:  prdata = {16'b0, scr_w};
      tet_pkg::REG_SCREEN_H:  prdata = {16'b0, scr_h};
      tet_pkg::REG_SINGLE_XL: prdata = s_xl;
      tet_pkg::REG_SINGLE_YL: prdata = s_yl;
      tet_pkg::REG_MULTI_XL:  prdata = m_xl;
      tet_pkg::REG_MULTI_YL:  prdata = m_yl;
      tet_pkg::REG_KEY_COUNT: prdata = {27'b0, key_count};
      default:                prdata = '0;
    endcase
  end

  // state
  tet_pkg::state_t state, state_next;
  logic [31:0] spx, spx_next, spy, spy_next;
  logic [1:0]  ssb, ssb_next;
  logic [31:0] mpx, mpx_next, mpy, mpy_next;
  logic [1:0]  msb, msb_next;
  logic [31:0] down_x, down_x_next, down_y, down_y_next;
  logic        discard, discard_next;
  logic [15:0] last_key, last_key_next;
  logic        lws, lws_next;
  logic [1:0]  rp, rp_next;
  logic        trm, trm_next;
  logic        dis, dis_next;

  // captured item
  logic        it_cmd;
  logic [15:0] it_type;
  logic [15:0] it_code;
  logic [31:0] it_val;
  logic [3:0]  it_kidx;
  tet_pkg::key_entry_t it_entry;

  // scaling work registers
  logic [31:0] src_px, src_px_next, src_py, src_py_next;
  logic [31:0] src_xl, src_xl_next, src_yl, src_yl_next;
  logic        axis, axis_next;
  logic signed [49:0] prod, prod_next;
  logic [31:0] res_x, res_x_next, res_y, res_y_next;
  logic [CNT_W-1:0] scan_idx, scan_idx_next, scan_n, scan_n_next;

  // pending result
  logic [15:0] pend_type, pend_type_next, pend_code, pend_code_next;
  logic [31:0] pend_val, pend_val_next;
  logic        pend_pulse, pend_pulse_next;

  // output register
  logic        out_valid, out_valid_next;
  logic        out_load;

  // key table memory
  tet_pkg::key_entry_t key_mem [MAX_KEYS];
  tet_pkg::key_entry_t rd_q;
  logic             mem_wr;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;

  // divider
  logic                 div_start;
  logic signed [16:0]   div_den;
  tet_pkg::div_status_t div_st;
  logic [31:0]          div_quo;

  // datapath helpers
  logic [31:0]        pos_sel;
  logic [31:0]        lim_sel;
  logic [15:0]        size_sel;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic               lim_eq;
  logic               rel_cond;
  logic signed [33:0] dx, dy;
  logic [33:0]        ax, ay;
  logic               hit;
  logic [CNT_W-1:0]   idx_inc;
  logic [CNT_W-1:0]   n_clamp;

  assign events.ready = (state == tet_pkg::S_IDLE);

  // item capture
  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      it_cmd        <= events.cmd;
      it_type       <= events.ev_type;
      it_code       <= events.ev_code;
      it_val        <= events.ev_value;
      it_kidx       <= events.key_index;
      it_entry.scan <= events.key_scancode;
      it_entry.cx   <= events.key_center_x;
      it_entry.cy   <= events.key_center_y;
      it_entry.w    <= events.key_width;
      it_entry.h    <= events.key_height;
    end
  end

  // key table: one write port, one registered read port
  assign wr_addr = IDX_W'(it_kidx);
  assign rd_addr = scan_idx[IDX_W-1:0];
  assign mem_wr  = (state == tet_pkg::S_DECODE) && it_cmd && (32'(it_kidx) < MAX_KEYS);

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      key_mem[wr_addr] <= it_entry;
    end
    rd_q <= key_mem[rd_addr];
  end

  // scaling operands for the current axis
  assign pos_sel  = axis ? src_py : src_px;
  assign lim_sel  = axis ? src_yl : src_xl;
  assign size_sel = axis ? scr_h : scr_w;
  assign mul_a    = $signed({pos_sel[31], pos_sel}) -
                    $signed({{17{lim_sel[15]}}, lim_sel[15:0]});
  assign mul_b    = $signed({1'b0, size_sel}) - 17'sd1;
  assign div_den  = $signed({lim_sel[31], lim_sel[31:16]}) -
                    $signed({lim_sel[15], lim_sel[15:0]});

  tet_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (prod),
    .den    (div_den),
    .status (div_st),
    .quo    (div_quo)
  );

  // virtual key hit test against the entry just read
  assign dx  = $signed({18'b0, rd_q.cx}) - $signed({{2{res_x[31]}}, res_x});
  assign dy  = $signed({18'b0, rd_q.cy}) - $signed({{2{res_y[31]}}, res_y});
  assign ax  = dx[33] ? 34'(-dx) : 34'(dx);
  assign ay  = dy[33] ? 34'(-dy) : 34'(dy);
  assign hit = (ax < 34'(rd_q.w[15:1])) && (ay < 34'(rd_q.h[15:1]));
  assign idx_inc = scan_idx + 1'b1;
  assign n_clamp = (32'(key_count) < MAX_KEYS) ? CNT_W'(key_count) : CNT_W'(MAX_KEYS);

  assign rel_cond = ((lws || rp == 2'd1) && !trm) || (trm && rp == 2'd2);
  // equal limits on the source that the report will use
  assign lim_eq   = (ssb != 2'b00) ?
                    ((s_xl[15:0] == s_xl[31:16]) || (s_yl[15:0] == s_yl[31:16])) :
                    ((m_xl[15:0] == m_xl[31:16]) || (m_yl[15:0] == m_yl[31:16]));

  // next state and datapath updates
  always_comb begin
    state_next      = state;
    spx_next        = spx;
    spy_next        = spy;
    ssb_next        = ssb;
    mpx_next        = mpx;
    mpy_next        = mpy;
    msb_next        = msb;
    down_x_next     = down_x;
    down_y_next     = down_y;
    discard_next    = discard;
    last_key_next   = last_key;
    lws_next        = lws;
    rp_next         = rp;
    trm_next        = trm;
    dis_next        = dis;
    src_px_next     = src_px;
    src_py_next     = src_py;
    src_xl_next     = src_xl;
    src_yl_next     = src_yl;
    axis_next       = axis;
    prod_next       = prod;
    res_x_next      = res_x;
    res_y_next      = res_y;
    scan_idx_next   = scan_idx;
    scan_n_next     = scan_n;
    pend_type_next  = pend_type;
    pend_code_next  = pend_code;
    pend_val_next   = pend_val;
    pend_pulse_next = pend_pulse;
    div_start       = 1'b0;
    out_load        = 1'b0;

    case (state)
      tet_pkg::S_IDLE: begin
        if (events.valid) begin
          state_next = tet_pkg::S_DECODE;
        end
      end

      // classify the event and latch positions
      tet_pkg::S_DECODE: begin
        pend_type_next  = it_type;
        pend_code_next  = it_code;
        pend_val_next   = it_val;
        pend_pulse_next = 1'b0;
        state_next      = tet_pkg::S_IDLE;
        if (it_cmd || dis) begin
          state_next = tet_pkg::S_IDLE;
        end else if (it_type == tet_pkg::EV_REL && it_code == tet_pkg::REL_Z) begin
          dis_next = 1'b1;
        end else if (it_type == tet_pkg::EV_KEY) begin
          state_next = tet_pkg::S_EMIT;
        end else if (it_type == tet_pkg::EV_ABS) begin
          lws_next = 1'b0;
          case (it_code)
            tet_pkg::ABS_X: begin
              ssb_next = ssb | 2'b01;
              spx_next = it_val;
            end
            tet_pkg::ABS_Y: begin
              ssb_next = ssb | 2'b10;
              spy_next = it_val;
            end
            tet_pkg::ABS_MT_PACKED: begin
              msb_next   = 2'b11;
              state_next = tet_pkg::S_EVAL;
              if (it_val == tet_pkg::RELEASE_SENTINEL) begin
                mpx_next = '0;
                mpy_next = '0;
                lws_next = 1'b1;
              end else begin
                mpx_next = (it_val & tet_pkg::PACK_X_MASK) >> 16;
                mpy_next = {16'b0, it_val[15:0]};
              end
            end
            tet_pkg::ABS_MT_MAJOR, tet_pkg::ABS_MT_FORCE: begin
              if (it_val == '0) begin
                mpx_next = '0;
                mpy_next = '0;
                rp_next  = 2'd1;
              end
            end
            tet_pkg::ABS_MT_POS_X: begin
              msb_next = msb | 2'b01;
              mpx_next = it_val;
            end
            tet_pkg::ABS_MT_POS_Y: begin
              msb_next = msb | 2'b10;
              mpy_next = it_val;
            end
            tet_pkg::ABS_MT_MINOR, tet_pkg::ABS_MT_WMAJOR, tet_pkg::ABS_MT_WMINOR: ;
            tet_pkg::ABS_MT_TRACK_ID: begin
              if (it_val[31]) begin
                mpx_next = '0;
                mpy_next = '0;
                rp_next  = 2'd2;
                trm_next = 1'b1;
              end
            end
            default: begin
              // unknown absolute code keeps the sync flag
              lws_next = lws;
            end
          endcase
        end else if (it_code != tet_pkg::ABS_MT_PACKED &&
                     (it_type != tet_pkg::EV_SYN ||
                      (it_code != tet_pkg::SYNC_FRAME && it_code != tet_pkg::SYNC_CONTACT))) begin
          lws_next   = 1'b0;
          state_next = tet_pkg::S_EMIT;
        end else if (it_code == tet_pkg::SYNC_CONTACT) begin
          state_next = tet_pkg::S_EMIT;
        end else begin
          state_next = tet_pkg::S_EVAL;
        end
      end

      // release check, then pick a position source
      tet_pkg::S_EVAL: begin
        state_next = tet_pkg::S_IDLE;
        if (rel_cond) begin
          rp_next     = 2'd0;
          down_x_next = tet_pkg::POS_NONE;
          down_y_next = tet_pkg::POS_NONE;
          pend_pulse_next = 1'b0;
          if (discard) begin
            discard_next   = 1'b0;
            pend_type_next = tet_pkg::EV_KEY;
            pend_code_next = last_key;
            pend_val_next  = '0;
          end else begin
            pend_type_next = tet_pkg::EV_ABS;
            pend_code_next = tet_pkg::CODE_RELEASE;
            pend_val_next  = {down_x[15:0], 16'b0} | down_y;
          end
          state_next = tet_pkg::S_EMIT;
        end else begin
          lws_next = 1'b1;
          if (ssb != 2'b00 || msb != 2'b00) begin
            if (ssb != 2'b00) begin
              src_px_next = spx;
              src_py_next = spy;
              src_xl_next = s_xl;
              src_yl_next = s_yl;
            end else begin
              src_px_next = mpx;
              src_py_next = mpy;
              src_xl_next = m_xl;
              src_yl_next = m_yl;
            end
            ssb_next  = 2'b00;
            msb_next  = 2'b00;
            axis_next = 1'b0;
            if (lim_eq) begin
              res_x_next = src_px_next;
              res_y_next = src_py_next;
              state_next = tet_pkg::S_POST;
            end else begin
              state_next = tet_pkg::S_MUL;
            end
          end
        end
      end

      tet_pkg::S_MUL: begin
        prod_next  = mul_a * mul_b;
        state_next = tet_pkg::S_DIVGO;
      end

      tet_pkg::S_DIVGO: begin
        div_start  = 1'b1;
        state_next = tet_pkg::S_DIVWAIT;
      end

      tet_pkg::S_DIVWAIT: begin
        if (div_st.done) begin
          if (axis) begin
            res_y_next = div_quo;
            state_next = tet_pkg::S_POST;
          end else begin
            res_x_next = div_quo;
            axis_next  = 1'b1;
            state_next = tet_pkg::S_MUL;
          end
        end
      end

      // drop absent positions, start the key search on first touch
      tet_pkg::S_POST: begin
        if (res_x == tet_pkg::POS_NONE || res_y == tet_pkg::POS_NONE ||
            (res_x == '0 && res_y == '0)) begin
          state_next = tet_pkg::S_IDLE;
        end else if (down_x == tet_pkg::POS_NONE && n_clamp != '0) begin
          scan_idx_next = '0;
          scan_n_next   = n_clamp;
          state_next    = tet_pkg::S_RD;
        end else begin
          state_next = tet_pkg::S_FINAL;
        end
      end

      tet_pkg::S_RD: begin
        state_next = tet_pkg::S_CHK;
      end

      tet_pkg::S_CHK: begin
        if (hit) begin
          last_key_next   = rd_q.scan;
          discard_next    = 1'b1;
          down_x_next     = '0;
          pend_type_next  = tet_pkg::EV_KEY;
          pend_code_next  = rd_q.scan;
          pend_val_next   = 32'd1;
          pend_pulse_next = 1'b1;
          state_next      = tet_pkg::S_EMIT;
        end else begin
          scan_idx_next = idx_inc;
          state_next    = (idx_inc == scan_n) ? tet_pkg::S_FINAL : tet_pkg::S_RD;
        end
      end

      tet_pkg::S_FINAL: begin
        if (discard) begin
          state_next = tet_pkg::S_IDLE;
        end else begin
          down_x_next     = res_x;
          down_y_next     = res_y;
          pend_type_next  = tet_pkg::EV_ABS;
          pend_code_next  = tet_pkg::CODE_TOUCH;
          pend_val_next   = {res_x[15:0], 16'b0} | res_y;
          pend_pulse_next = 1'b0;
          state_next      = tet_pkg::S_EMIT;
        end
      end

      // wait for a free output register
      tet_pkg::S_EMIT: begin
        if (!out_valid || results.ready) begin
          out_load   = 1'b1;
          state_next = tet_pkg::S_IDLE;
        end
      end

      default: state_next = tet_pkg::S_IDLE;
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_next = out_valid;
    if (results.ready) begin
      out_valid_next = 1'b0;
    end
    if (out_load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tet_pkg::S_IDLE;
      spx       <= '0;
      spy       <= '0;
      ssb       <= '0;
      mpx       <= '0;
      mpy       <= '0;
      msb       <= '0;
      down_x    <= tet_pkg::POS_NONE;
      down_y    <= tet_pkg::POS_NONE;
      discard   <= 1'b0;
      last_key  <= '0;
      lws       <= 1'b0;
      rp        <= '0;
      trm       <= 1'b0;
      dis       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      spx       <= spx_next;
      spy       <= spy_next;
      ssb       <= ssb_next;
      mpx       <= mpx_next;
      mpy       <= mpy_next;
      msb       <= msb_next;
      down_x    <= down_x_next;
      down_y    <= down_y_next;
      discard   <= discard_next;
      last_key  <= last_key_next;
      lws       <= lws_next;
      rp        <= rp_next;
      trm       <= trm_next;
      dis       <= dis_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    src_px     <= src_px_next;
    src_py     <= src_py_next;
    src_xl     <= src_xl_next;
    src_yl     <= src_yl_next;
    axis       <= axis_next;
    prod       <= prod_next;
    res_x      <= res_x_next;
    res_y      <= res_y_next;
    scan_idx   <= scan_idx_next;
    scan_n     <= scan_n_next;
    pend_type  <= pend_type_next;
    pend_code  <= pend_code_next;
    pend_val   <= pend_val_next;
    pend_pulse <= pend_pulse_next;
    if (out_load) begin
      results.out_type     <= pend_type;
      results.out_code     <= pend_code;
      results.out_value    <= pend_val;
      results.haptic_pulse <= pend_pulse;
    end
  end

  assign results.valid = out_valid;

endmodule

// ===== sv/tet_div.sv =====
module tet_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [tet_pkg::DIV_NUM_W-1:0]  num,
  input  logic signed [tet_pkg::DIV_DEN_W-1:0]  den,
  output tet_pkg::div_status_t                  status,
  output logic [31:0]                           quo
);

  logic [tet_pkg::DIV_MAG_W-1:0] mag;
  logic [tet_pkg::DIV_REM_W-1:0] dmag;
  logic [tet_pkg::DIV_REM_W-1:0] rem;
  logic [tet_pkg::DIV_CNT_W-1:0] cnt;
  logic                          neg;
  logic                          busy;
  logic                          done;

  logic [tet_pkg::DIV_REM_W:0]   shifted;
  logic                          qbit;
  logic [tet_pkg::DIV_MAG_W-1:0] quo_signed;

  // one restoring step per cycle
  assign shifted = {rem, mag[tet_pkg::DIV_MAG_W-1]};
  assign qbit    = shifted >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= tet_pkg::DIV_CNT_W'(tet_pkg::DIV_MAG_W);
        rem  <= '0;
        neg  <= num[tet_pkg::DIV_NUM_W-1] ^ den[tet_pkg::DIV_DEN_W-1];
        mag  <= num[tet_pkg::DIV_NUM_W-1] ? tet_pkg::DIV_MAG_W'(-num)
                                          : tet_pkg::DIV_MAG_W'(num);
        dmag <= den[tet_pkg::DIV_DEN_W-1] ? tet_pkg::DIV_REM_W'(-den)
                                          : tet_pkg::DIV_REM_W'(den);
      end else if (busy) begin
        rem <= qbit ? tet_pkg::DIV_REM_W'(shifted - {1'b0, dmag})
                    : tet_pkg::DIV_REM_W'(shifted);
        mag <= {mag[tet_pkg::DIV_MAG_W-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == tet_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // sign fix, truncation toward zero
  assign quo_signed = neg ? -mag : mag;
  assign quo        = quo_signed[31:0];
  assign status     = '{busy: busy, done: done};

endmodule

// ===== sv/tet_checker.sv =====
module tet_checker (
  input logic        clk,
  input logic        rst,
  input logic        ev_valid,
  input logic        ev_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] res_type,
  input logic        res_pulse,
  input logic        pready
);

  // output register is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("stalled result dropped");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    ev_valid && ev_ready |=> !ev_ready)
    else $error("second item taken while one is in work");

  // haptic pulse only on a key event
  a_pulse_key: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_pulse |-> res_type == tet_pkg::EV_KEY)
    else $error("haptic pulse on a non-key event");

  // config port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind touch_event_translator tet_checker u_tet_checker (
  .clk       (clk),
  .rst       (rst),
  .ev_valid  (events.valid),
  .ev_ready  (events.ready),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_type  (results.out_type),
  .res_pulse (results.haptic_pulse),
  .pready    (pready)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 250;
  localparam int NKEYS       = 16;

  typedef struct {
    bit          cmd;
    logic [15:0] typ;
    logic [15:0] code;
    logic [31:0] val;
    logic [3:0]  kidx;
    tet_pkg::key_entry_t kent;
  } raw_event_t;

  typedef struct {
    logic [15:0] typ;
    logic [15:0] code;
    logic [31:0] val;
    logic        pulse;
  } touch_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tet_event_if  ev ();
  tet_result_if res ();

  touch_event_translator dut (
    .clk(clk), .rst(rst), .events(ev), .results(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  raw_event_t    pending_events[$];
  touch_result_t expected_events[$];
  int unsigned   cycles = 0;
  int            mismatches = 0;
  bit            ev_took = 0;
  bit            long_stall_go = 0;
  bit            long_stall_done = 0;
  int            hold_left = 0;

  // shadow configuration
  logic [15:0] scr_w, scr_h;
  logic [31:0] sx_lim, sy_lim, mx_lim, my_lim;
  logic [4:0]  key_cnt;

  // shadow tracking state
  logic [31:0] s_x, s_y, m_x, m_y, dn_x, dn_y;
  logic [1:0]  s_bits, m_bits, rel_pend;
  logic        discard, was_sync, trk_mode, disabled;
  logic [15:0] last_scan;
  tet_pkg::key_entry_t key_tab[NKEYS];

  function automatic logic [31:0] scale_axis(logic [31:0] pos, logic [31:0] lim,
                                             logic [15:0] size);
    longint mn, mx, num;
    mn  = longint'($signed(lim[15:0]));
    mx  = longint'($signed(lim[31:16]));
    num = (longint'($signed(pos)) - mn) * (longint'({48'd0, size}) - 1);
    return 32'(num / (mx - mn));
  endfunction

  function automatic void map_to_screen(logic [31:0] px, logic [31:0] py,
                                        logic [31:0] xl, logic [31:0] yl,
                                        output logic [31:0] x, output logic [31:0] y);
    if (xl[15:0] == xl[31:16] || yl[15:0] == yl[31:16]) begin
      x = px;
      y = py;
    end else begin
      x = scale_axis(px, xl, scr_w);
      y = scale_axis(py, yl, scr_h);
    end
  endfunction

  function automatic void add_expect(logic [15:0] t, logic [15:0] c, logic [31:0] v,
                                     logic h);
    touch_result_t r;
    r.typ = t;
    r.code = c;
    r.val = v;
    r.pulse = h;
    expected_events.push_back(r);
  endfunction

  // expected translator behavior for one accepted transfer
  function automatic void predict_event(raw_event_t e);
    logic [31:0] x, y, packed_pos;
    longint xd, yd;
    int n;
    if (e.cmd) begin
      key_tab[e.kidx] = e.kent;
      return;
    end
    if (disabled) return;
    if (e.typ == tet_pkg::EV_REL && e.code == tet_pkg::REL_Z) begin
      disabled = 1'b1;
      return;
    end
    if (e.typ == tet_pkg::EV_KEY) begin
      add_expect(e.typ, e.code, e.val, 1'b0);
      return;
    end
    if (e.typ == tet_pkg::EV_ABS) begin
      case (e.code)
        tet_pkg::ABS_X: begin s_bits[0] = 1'b1; s_x = e.val; end
        tet_pkg::ABS_Y: begin s_bits[1] = 1'b1; s_y = e.val; end
        tet_pkg::ABS_MT_PACKED: begin
          m_bits = 2'b11;
          if (e.val == tet_pkg::RELEASE_SENTINEL) begin
            m_x = '0; m_y = '0;
            was_sync = 1'b1;
          end else begin
            was_sync = 1'b0;
            m_x = (e.val & tet_pkg::PACK_X_MASK) >> 16;
            m_y = {16'd0, e.val[15:0]};
          end
        end
        tet_pkg::ABS_MT_MAJOR, tet_pkg::ABS_MT_FORCE: begin
          if (e.val == '0) begin
            m_x = '0; m_y = '0;
            rel_pend = 2'd1;
          end
        end
        tet_pkg::ABS_MT_POS_X: begin m_bits[0] = 1'b1; m_x = e.val; end
        tet_pkg::ABS_MT_POS_Y: begin m_bits[1] = 1'b1; m_y = e.val; end
        tet_pkg::ABS_MT_MINOR, tet_pkg::ABS_MT_WMAJOR, tet_pkg::ABS_MT_WMINOR: ;
        tet_pkg::ABS_MT_TRACK_ID: begin
          if (e.val[31]) begin
            m_x = '0; m_y = '0;
            rel_pend = 2'd2;
            trk_mode = 1'b1;
          end
        end
        default: return;
      endcase
      if (e.code != tet_pkg::ABS_MT_PACKED) begin
        was_sync = 1'b0;
        return;
      end
    end
    if (e.code != tet_pkg::ABS_MT_PACKED &&
        (e.typ != tet_pkg::EV_SYN ||
         (e.code != tet_pkg::SYNC_FRAME && e.code != tet_pkg::SYNC_CONTACT))) begin
      was_sync = 1'b0;
      add_expect(e.typ, e.code, e.val, 1'b0);
      return;
    end
    if (e.code == tet_pkg::SYNC_CONTACT) begin
      add_expect(e.typ, e.code, e.val, 1'b0);
      return;
    end
    // release report
    if (((was_sync || rel_pend == 2'd1) && !trk_mode) || (trk_mode && rel_pend == 2'd2)) begin
      packed_pos = (dn_x << 16) | dn_y;
      rel_pend = 2'd0;
      dn_x = tet_pkg::POS_NONE;
      dn_y = tet_pkg::POS_NONE;
      if (discard) begin
        discard = 1'b0;
        add_expect(tet_pkg::EV_KEY, last_scan, '0, 1'b0);
      end else begin
        add_expect(tet_pkg::EV_ABS, tet_pkg::CODE_RELEASE, packed_pos, 1'b0);
      end
      return;
    end
    was_sync = 1'b1;
    if (s_bits != 2'b00) map_to_screen(s_x, s_y, sx_lim, sy_lim, x, y);
    else if (m_bits != 2'b00) map_to_screen(m_x, m_y, mx_lim, my_lim, x, y);
    else return;
    s_bits = '0;
    m_bits = '0;
    if (x == tet_pkg::POS_NONE || y == tet_pkg::POS_NONE) return;
    if (x == '0 && y == '0) return;
    // virtual key search on first touch
    if (dn_x == tet_pkg::POS_NONE) begin
      n = (key_cnt < NKEYS) ? key_cnt : NKEYS;
      for (int i = 0; i < n; i++) begin
        xd = longint'({48'd0, key_tab[i].cx}) - longint'($signed(x));
        yd = longint'({48'd0, key_tab[i].cy}) - longint'($signed(y));
        if (xd < 0) xd = -xd;
        if (yd < 0) yd = -yd;
        if (xd < longint'({48'd0, key_tab[i].w >> 1}) &&
            yd < longint'({48'd0, key_tab[i].h >> 1})) begin
          last_scan = key_tab[i].scan;
          discard = 1'b1;
          dn_x = '0;
          add_expect(tet_pkg::EV_KEY, key_tab[i].scan, 32'd1, 1'b1);
          return;
        end
      end
    end
    if (discard) return;
    dn_x = x;
    dn_y = y;
    add_expect(tet_pkg::EV_ABS, tet_pkg::CODE_TOUCH, (x << 16) | y, 1'b0);
  endfunction

  function automatic int pick_gap();
    int r;
    if (cycles[12:11] == 2'b11 || hold_left > 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // input transfer monitor
  always @(posedge clk) begin
    raw_event_t e;
    ev_took = !rst && ev.valid && ev.ready;
    if (ev_took) begin
      e.cmd = ev.cmd;
      e.typ = ev.ev_type;
      e.code = ev.ev_code;
      e.val = ev.ev_value;
      e.kidx = ev.key_index;
      e.kent.scan = ev.key_scancode;
      e.kent.cx = ev.key_center_x;
      e.kent.cy = ev.key_center_y;
      e.kent.w = ev.key_width;
      e.kent.h = ev.key_height;
      predict_event(e);
    end
  end

  // result transfer check
  always @(posedge clk) begin
    touch_result_t want;
    if (!rst && res.valid && res.ready) begin
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: type %h code %h value %h pulse %b",
                   res.out_type, res.out_code, res.out_value, res.haptic_pulse);
      end else begin
        want = expected_events.pop_front();
        if (res.out_type !== want.typ || res.out_code !== want.code ||
            res.out_value !== want.val || res.haptic_pulse !== want.pulse) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%h/%h/%b got %h/%h/%h/%b",
                     want.typ, want.code, want.val, want.pulse, res.out_type,
                     res.out_code, res.out_value, res.haptic_pulse);
        end
      end
    end
  end

  // event driver
  int ev_gap = 0;
  always @(negedge clk) begin
    raw_event_t e;
    if (!rst && (!ev.valid || ev_took)) begin
      if (ev_gap > 0 && hold_left == 0) begin
        ev_gap--;
        ev.valid <= 1'b0;
      end else if (pending_events.size() > 0) begin
        e = pending_events.pop_front();
        ev.cmd <= e.cmd;
        ev.ev_type <= e.typ;
        ev.ev_code <= e.code;
        ev.ev_value <= e.val;
        ev.key_index <= e.kidx;
        ev.key_scancode <= e.kent.scan;
        ev.key_center_x <= e.kent.cx;
        ev.key_center_y <= e.kent.cy;
        ev.key_width <= e.kent.w;
        ev.key_height <= e.kent.h;
        ev.valid <= 1'b1;
        ev_gap = pick_gap();
      end else begin
        ev.valid <= 1'b0;
      end
    end
  end

  // result receiver with random and long stalls
  int rdy_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (long_stall_go && !long_stall_done) begin
        long_stall_done = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (rdy_gap > 0) begin
        rdy_gap--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        rdy_gap = pick_gap();
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      tet_pkg::REG_SCREEN_W:  scr_w = data[15:0];
      tet_pkg::REG_SCREEN_H:  scr_h = data[15:0];
      tet_pkg::REG_SINGLE_XL: sx_lim = data;
      tet_pkg::REG_SINGLE_YL: sy_lim = data;
      tet_pkg::REG_MULTI_XL:  mx_lim = data;
      tet_pkg::REG_MULTI_YL:  my_lim = data;
      tet_pkg::REG_KEY_COUNT: key_cnt = data[4:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic push_event(logic [15:0] t, logic [15:0] c, logic [31:0] v);
    raw_event_t e;
    e.cmd = 1'b0;
    e.typ = t;
    e.code = c;
    e.val = v;
    e.kidx = 4'($urandom);
    e.kent = tet_pkg::key_entry_t'(80'({$urandom, $urandom, $urandom}));
    pending_events.push_back(e);
  endtask

  task automatic push_key(logic [3:0] idx, tet_pkg::key_entry_t k);
    raw_event_t e;
    e.cmd = 1'b1;
    e.typ = 16'($urandom);
    e.code = 16'($urandom);
    e.val = $urandom;
    e.kidx = idx;
    e.kent = k;
    pending_events.push_back(e);
  endtask

  // wait for every expected result, then for the block to settle
  task automatic drain();
    while (pending_events.size() > 0 || ev.valid || expected_events.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2000);
    if (r < 80) return 32'hFFFFFFFF;
    if (r < 85) return '0;
    if (r < 95) return 32'($signed($urandom_range(0, 80000)) - 20000);
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_lim();
    logic [15:0] a, b;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return {16'h7FFF, 16'h8000};
    if (r == 1) return {16'($urandom), 16'($urandom)};
    if (r == 2) begin
      a = 16'($urandom);
      return {a, a};
    end
    a = 16'($urandom_range(0, 200));
    b = 16'($urandom_range(1000, 4000));
    return {b, a};
  endfunction

  // one random burst of touch traffic
  task automatic random_traffic(int count);
    logic [31:0] x, y;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      x = rand_pos();
      y = rand_pos();
      if (r < 25) begin
        push_event(tet_pkg::EV_ABS, tet_pkg::ABS_X, x);
        push_event(tet_pkg::EV_ABS, tet_pkg::ABS_Y, y);
        push_event(tet_pkg::EV_SYN, tet_pkg::SYNC_FRAME, 32'($urandom_range(0, 1)));
      end else if (r < 45) begin
        push_event(tet_pkg::EV_ABS, tet_pkg::ABS_MT_POS_X, x);
        push_event(tet_pkg::EV_ABS, tet_pkg::ABS_MT_POS_Y, y);
        if ($urandom_range(0, 1))
          push_event(tet_pkg::EV_SYN, tet_pkg::SYNC_CONTACT, $urandom);
        push_event(tet_pkg::EV_SYN, tet_pkg::SYNC_FRAME, '0);
      end else if (r < 55) begin
        push_event(tet_pkg::EV_ABS, tet_pkg::ABS_MT_PACKED, {1'b0, x[14:0], y[15:0]});
      end else if (r < 70) begin
        case ($urandom_range(0, 3))
          0: push_event(tet_pkg::EV_ABS, tet_pkg::ABS_MT_MAJOR,
                        $urandom_range(0, 1) ? '0 : $urandom);
          1: push_event(tet_pkg::EV_ABS, tet_pkg::ABS_MT_FORCE, '0);
          2: push_event(tet_pkg::EV_ABS, tet_pkg::ABS_MT_TRACK_ID,
                        $urandom_range(0, 1) ? 32'hFFFFFFFF : $urandom);
          default: push_event(tet_pkg::EV_ABS, tet_pkg::ABS_MT_PACKED,
                              tet_pkg::RELEASE_SENTINEL);
        endcase
        push_event(tet_pkg::EV_SYN, tet_pkg::SYNC_FRAME, '0);
      end else if (r < 78) begin
        push_event(tet_pkg::EV_SYN, tet_pkg::SYNC_FRAME, '0);
      end else if (r < 84) begin
        push_event(tet_pkg::EV_ABS,
                   16'($urandom_range(tet_pkg::ABS_MT_MINOR, tet_pkg::ABS_MT_WMINOR)),
                   $urandom);
      end else if (r < 88) begin
        push_event(tet_pkg::EV_KEY, 16'($urandom), $urandom);
      end else if (r < 93) begin
        push_event(16'($urandom), 16'($urandom), $urandom);
      end else if (r < 96) begin
        push_event(tet_pkg::EV_ABS, 16'($urandom), $urandom);
      end else begin
        push_event(16'($urandom_range(0, 3)), tet_pkg::ABS_MT_PACKED, $urandom);
      end
    end
  endtask

  initial begin
    tet_pkg::key_entry_t k;
    ev.valid = 1'b0; ev.cmd = 1'b0; ev.ev_type = '0; ev.ev_code = '0;
    ev.ev_value = '0; ev.key_index = '0; ev.key_scancode = '0;
    ev.key_center_x = '0; ev.key_center_y = '0; ev.key_width = '0;
    ev.key_height = '0;
    res.ready = 1'b0;
    scr_w = 16'd1080; scr_h = 16'd1920;
    sx_lim = '0; sy_lim = '0; mx_lim = '0; my_lim = '0; key_cnt = '0;
    s_x = '0; s_y = '0; m_x = '0; m_y = '0; s_bits = '0; m_bits = '0;
    dn_x = tet_pkg::POS_NONE; dn_y = tet_pkg::POS_NONE; rel_pend = '0;
    discard = 1'b0; was_sync = 1'b0; trk_mode = 1'b0; disabled = 1'b0;
    last_scan = '0;
    for (int i = 0; i < NKEYS; i++) key_tab[i] = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill the key table before any key count covers it
    for (int i = 0; i < NKEYS; i++) begin
      k.scan = (i == 0) ? 16'hFFFF : 16'($urandom);
      k.cx = (i == 1) ? 16'hFFFF : 16'($urandom_range(0, 1500));
      k.cy = (i == 1) ? 16'hFFFF : 16'($urandom_range(0, 2000));
      k.w = (i == 2) ? 16'hFFFF : 16'($urandom_range(0, 600));
      k.h = (i == 2) ? 16'hFFFF : 16'($urandom_range(0, 600));
      push_key(4'(i), k);
    end

    // directed: extremes, releases, forwarding
    push_event(tet_pkg::EV_ABS, tet_pkg::ABS_X, 32'h7FFFFFFF);
    push_event(tet_pkg::EV_ABS, tet_pkg::ABS_Y, 32'h80000000);
    push_event(tet_pkg::EV_SYN, tet_pkg::SYNC_FRAME, '0);
    push_event(tet_pkg::EV_ABS, tet_pkg::ABS_MT_MAJOR, '0);
    push_event(tet_pkg::EV_SYN, tet_pkg::SYNC_FRAME, '0);
    push_event(tet_pkg::EV_ABS, tet_pkg::ABS_MT_PACKED, 32'h7FFFFFFF);
    push_event(tet_pkg::EV_ABS, tet_pkg::ABS_MT_PACKED, tet_pkg::RELEASE_SENTINEL);
    push_event(tet_pkg::EV_SYN, tet_pkg::SYNC_CONTACT, 32'hFFFFFFFF);
    push_event(tet_pkg::EV_KEY, 16'hFFFF, 32'h80000000);
    push_event(16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
    push_event(tet_pkg::EV_ABS, 16'hFFFF, '0);
    push_event(tet_pkg::EV_ABS, tet_pkg::ABS_MT_TRACK_ID, 32'hFFFFFFFF);
    push_event(tet_pkg::EV_SYN, tet_pkg::SYNC_FRAME, '0);
    push_event(tet_pkg::EV_REL, 16'h0000, 32'd5);
    drain();

    // configuration phases, extremes first
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          reg_write(tet_pkg::REG_SCREEN_W, 32'd1);
          reg_write(tet_pkg::REG_SCREEN_H, 32'd1);
          reg_write(tet_pkg::REG_KEY_COUNT, 32'd0);
        end
        1: begin
          reg_write(tet_pkg::REG_SCREEN_W, 32'd65535);
          reg_write(tet_pkg::REG_SCREEN_H, 32'd65535);
          reg_write(tet_pkg::REG_KEY_COUNT, 32'd31);
        end
        2: begin
          reg_write(tet_pkg::REG_SCREEN_W, 32'd1080);
          reg_write(tet_pkg::REG_SCREEN_H, 32'd1920);
          reg_write(tet_pkg::REG_KEY_COUNT, 32'd16);
        end
        default: begin
          reg_write(tet_pkg::REG_SCREEN_W, 32'($urandom_range(1, 65535)));
          reg_write(tet_pkg::REG_SCREEN_H, 32'($urandom_range(1, 65535)));
          reg_write(tet_pkg::REG_KEY_COUNT, 32'($urandom_range(0, 20)));
        end
      endcase
      reg_write(tet_pkg::REG_SINGLE_XL, (ph == 0) ? 32'hFFFFFFFF : rand_lim());
      reg_write(tet_pkg::REG_SINGLE_YL, (ph == 1) ? 32'h00000000 : rand_lim());
      reg_write(tet_pkg::REG_MULTI_XL, (ph == 2) ? {16'h7FFF, 16'h8000} : rand_lim());
      reg_write(tet_pkg::REG_MULTI_YL, (ph == 3) ? {16'h8000, 16'h7FFF} : rand_lim());
      if (ph == 2) long_stall_go = 1;
      random_traffic(95);
      drain();
    end

    // disable by z motion, then table writes and events that are dropped
    push_event(tet_pkg::EV_REL, tet_pkg::REL_Z, 32'd1);
    push_key(4'd3, tet_pkg::key_entry_t'(80'({$urandom, $urandom, $urandom})));
    push_event(tet_pkg::EV_KEY, 16'd30, 32'd1);
    push_event(tet_pkg::EV_ABS, tet_pkg::ABS_X, 32'd100);
    push_event(tet_pkg::EV_SYN, tet_pkg::SYNC_FRAME, '0);
    drain();

    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
